/* rtl/bqd_pkg.sv */
// Package: formats, constants and float helpers for the block dequantiser.
`default_nettype none
package bqd_pkg;
    localparam int LANES          = 4;
    localparam int BLOCK_ELEMENTS = 32;
    localparam int GROUPS         = BLOCK_ELEMENTS / LANES;
    localparam int GRP_W          = $clog2(GROUPS);

    typedef enum logic [1:0] {
        FMT_F32  = 2'd0,
        FMT_F16  = 2'd1,
        FMT_Q4_0 = 2'd2,
        FMT_Q8_0 = 2'd3
    } fmt_t;

    localparam logic [31:0] EXP_ALL   = 32'h7F80_0000;
    localparam logic [31:0] QNAN_DEF  = 32'h7FC0_0000;
    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

    // Exact half to single conversion.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  mant;
        logic [31:0] res;
        logic [3:0]  lz;
        logic [10:0] norm;
        ex   = h[14:10];
        mant = h[9:0];
        lz   = 4'd0;
        for (int b = 0; b < 10; b++)
        begin
            if (mant[b])
                lz = 4'(9 - b);
        end
        norm = {1'b0, mant} << (lz + 4'd1);
        if (ex == 5'd0)
        begin
            if (mant == 10'd0)
                res = {h[15], 31'd0};
            else
                res = {h[15], 8'(8'd112 - {4'd0, lz}), norm[9:0], 13'd0};
        end
        else if (ex == 5'h1F)
            res = {h[15], 31'd0} | EXP_ALL | {9'd0, mant, 13'd0};
        else
            res = {h[15], 8'({3'd0, ex} + 8'd112), mant, 13'd0};
        return res;
    endfunction
endpackage
`default_nettype wire

/* rtl/bqd_lane.sv */
// One lane: integer times half scale, or a raw value passed through, in three register stages.
`default_nettype none
module bqd_lane
    import bqd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic        is_scaled,
    input  wire logic [15:0] scale,
    input  wire logic [31:0] raw,
    input  wire logic [7:0]  qval,
    output logic [31:0]      result
);
    // stage 1: operand split and special cases
    logic        s1_spec_reg;
    logic [31:0] s1_spec_val_reg;
    logic        s1_sign_reg;
    logic [10:0] s1_m_reg;
    logic [7:0]  s1_mag_reg;
    logic [4:0]  s1_e_reg;
    // stage 2: product
    logic        s2_spec_reg;
    logic [31:0] s2_spec_val_reg;
    logic        s2_sign_reg;
    logic [18:0] s2_p_reg;
    logic [4:0]  s2_e_reg;

    logic        neg;
    logic [7:0]  mag;
    logic [4:0]  ex;
    logic [9:0]  mant;
    logic        sgn;
    logic        spec_next;
    logic [31:0] spec_val_next;
    logic [4:0]  t;
    logic [18:0] pn;

    always_comb
    begin
        neg  = qval[7];
        mag  = neg ? 8'(-qval) : qval;
        ex   = scale[14:10];
        mant = scale[9:0];
        sgn  = scale[15] ^ neg;
        spec_next     = 1'b1;
        spec_val_next = raw;
        if (is_scaled)
        begin
            if (ex == 5'h1F)
            begin
                if (mant != 10'd0)
                    spec_val_next = half_to_single(scale) | QUIET_BIT;
                else if (mag == 8'd0)
                    spec_val_next = QNAN_DEF;
                else
                    spec_val_next = {sgn, 31'd0} | EXP_ALL;
            end
            else if ((ex == 5'd0 && mant == 10'd0) || mag == 8'd0)
                spec_val_next = {sgn, 31'd0};
            else
                spec_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_spec_reg     <= spec_next;
            s1_spec_val_reg <= spec_val_next;
            s1_sign_reg     <= sgn;
            s1_m_reg        <= (ex != 5'd0) ? {1'b1, mant} : {1'b0, mant};
            s1_e_reg        <= (ex != 5'd0) ? ex : 5'd1;
            s1_mag_reg      <= mag;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
            s2_sign_reg     <= s1_sign_reg;
            s2_e_reg        <= s1_e_reg;
            s2_p_reg        <= 19'(s1_m_reg * s1_mag_reg);
        end
    end

    always_comb
    begin
        t = 5'd0;
        for (int b = 0; b < 19; b++)
        begin
            if (s2_p_reg[b])
                t = 5'(b);
        end
        pn = s2_p_reg << (5'd18 - t);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s2_spec_reg)
                result <= s2_spec_val_reg;
            else
                result <= {s2_sign_reg, 8'({3'd0, t} + {3'd0, s2_e_reg} + 8'd102),
                           pn[17:0], 5'd0};
        end
    end
endmodule
`default_nettype wire

/* rtl/block_quant_dequantizer.sv */
// Top level: block dequantiser, four single lanes per output beat.
//  channel | signals                             | dir
//  cfg     | cfg_valid cfg_ready cfg_data[1:0]   | in
//  in      | in_valid in_stall scale_half data_* | in
//  out     | out_valid out_stall lane0-3 last    | out
// f32/f16 beats give one output beat; Q4_0/Q8_0 give eight, one per cycle while
// out_stall is low, set by the output width of four lanes. The sequencer feeds
// the three lane register stages directly. Reset is asynchronous and sets format
// to Q4_0. A stall under a valid output freezes the whole pipe; nothing is lost.
`default_nettype none
module block_quant_dequantizer
    import bqd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] scale_half,
    input  wire logic [63:0] data_word0,
    input  wire logic [63:0] data_word1,
    input  wire logic [63:0] data_word2,
    input  wire logic [63:0] data_word3,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      lane0,
    output logic [31:0]      lane1,
    output logic [31:0]      lane2,
    output logic [31:0]      lane3,
    output logic             last_of_block
);
    fmt_t             fmt_reg;
    logic             busy_reg;
    logic [GRP_W-1:0] grp_reg;
    logic [GRP_W-1:0] grp_next;
    logic [15:0]      sc_reg;
    logic [255:0]     dat_reg;
    logic [2:0]       vld_reg;
    logic [2:0]       lst_reg;
    logic             adv;
    logic             blockfmt;
    logic             s0_valid;
    logic             s0_last;
    logic [GRP_W-1:0] g;
    logic [31:0]      raw   [LANES];
    logic [7:0]       q     [LANES];
    logic [31:0]      res   [LANES];
    logic [255:0]     cur_dat;
    logic [15:0]      cur_sc;

    assign cfg_ready = 1'b1;
    assign adv       = !(vld_reg[2] && out_stall);
    assign blockfmt  = fmt_reg[1];
    // take a new beat whenever the block sequencer is free and the pipe is not stalled
    assign in_stall  = busy_reg || !adv;

    always_comb
    begin
        s0_valid = busy_reg || in_valid;
        cur_dat  = busy_reg ? dat_reg : {data_word3, data_word2, data_word1, data_word0};
        cur_sc   = busy_reg ? sc_reg : scale_half;
        g        = busy_reg ? grp_reg : '0;
        grp_next = GRP_W'(g + 1'b1);
        s0_last  = !blockfmt || (g == GRP_W'(GROUPS - 1));
        for (int j = 0; j < LANES; j++)
        begin
            raw[j] = '0;
            q[j]   = '0;
            unique case (fmt_reg)
                FMT_F32:  raw[j] = cur_dat[32*j +: 32];
                FMT_F16:  raw[j] = half_to_single(cur_dat[16*j +: 16]);
                FMT_Q4_0:
                begin
                    // low nibbles then high nibbles, minus eight
                    if (g[2])
                        q[j] = 8'({4'd0, cur_dat[8*(((4*g)+j)%16) + 4 +: 4]}) - 8'd8;
                    else
                        q[j] = 8'({4'd0, cur_dat[8*(((4*g)+j)%16) +: 4]}) - 8'd8;
                end
                FMT_Q8_0: q[j] = cur_dat[8*((4*g)+j) +: 8];
                default:  raw[j] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_Q4_0;
            busy_reg <= 1'b0;
            grp_reg  <= '0;
            vld_reg  <= '0;
            lst_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                fmt_reg <= fmt_t'(cfg_data);
            if (adv)
            begin
                vld_reg <= {vld_reg[1:0], s0_valid};
                lst_reg <= {lst_reg[1:0], s0_last};
                if (s0_valid)
                begin
                    busy_reg <= !s0_last;
                    grp_reg  <= grp_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && !busy_reg && in_valid)
        begin
            dat_reg <= cur_dat;
            sc_reg  <= cur_sc;
        end
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        bqd_lane u_lane (
            .clk       (clk),
            .adv       (adv),
            .is_scaled (blockfmt),
            .scale     (cur_sc),
            .raw       (raw[j]),
            .qval      (q[j]),
            .result    (res[j])
        );
    end

    assign out_valid     = vld_reg[2];
    assign last_of_block = lst_reg[2];
    assign lane0 = res[0];
    assign lane1 = res[1];
    assign lane2 = res[2];
    assign lane3 = res[3];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lane0))
        else $error("result moved under stall");
    a_noacc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("beat accepted mid block");
    a_grp: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> blockfmt)
        else $error("sequencer busy outside a block format");
endmodule
`default_nettype wire

/* tb/block_quant_dequantizer_tb.sv */
// Testbench for the block dequantiser: random and directed blocks, checked against a predictor.
`timescale 1ns / 1ps
module block_quant_dequantizer_tb;
    import bqd_pkg::*;

    typedef struct packed {
        logic [15:0] scale;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
    } block_t;

    typedef struct packed {
        logic [31:0] l0;
        logic [31:0] l1;
        logic [31:0] l2;
        logic [31:0] l3;
        logic        last;
    } group_t;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_WAIT  = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] scale_half = 16'd0;
    logic [63:0] data_word0 = 64'd0;
    logic [63:0] data_word1 = 64'd0;
    logic [63:0] data_word2 = 64'd0;
    logic [63:0] data_word3 = 64'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] lane0, lane1, lane2, lane3;
    logic        last_of_block;

    fmt_t   model_fmt = FMT_Q4_0;
    group_t pending_groups[$];
    int     err_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    block_quant_dequantizer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .scale_half(scale_half),
        .data_word0(data_word0), .data_word1(data_word1),
        .data_word2(data_word2), .data_word3(data_word3),
        .out_valid(out_valid), .out_stall(out_stall),
        .lane0(lane0), .lane1(lane1), .lane2(lane2), .lane3(lane3),
        .last_of_block(last_of_block)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] widen_half(logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [10:0] mant;
        logic [7:0]  e;
        sgn  = {h[15], 31'd0};
        ex   = h[14:10];
        mant = {1'b0, h[9:0]};
        if (ex == 5'd0)
        begin
            if (mant == 11'd0)
                return sgn;
            e = 8'd113;
            while (!mant[10])
            begin
                mant = mant << 1;
                e    = e - 8'd1;
            end
            return sgn | {1'b0, e, mant[9:0], 13'd0};
        end
        if (ex == 5'h1F)
            return sgn | 32'h7F80_0000 | {9'd0, mant[9:0], 13'd0};
        return sgn | {1'b0, 8'({3'd0, ex} + 8'd112), mant[9:0], 13'd0};
    endfunction

    // Exact product of a half scale and a small signed integer.
    function automatic logic [31:0] scale_int(logic [15:0] h, int q);
        logic        neg;
        int unsigned mag, m, e, p, t;
        logic [31:0] sgn;
        neg = q < 0;
        mag = neg ? -q : q;
        sgn = {h[15] ^ neg, 31'd0};
        if (h[14:10] == 5'h1F)
        begin
            if (h[9:0] != 10'd0)
                return widen_half(h) | 32'h0040_0000;
            if (mag == 0)
                return 32'h7FC0_0000;
            return sgn | 32'h7F80_0000;
        end
        if (h[14:0] == 15'd0 || mag == 0)
            return sgn;
        m = (h[14:10] != 0) ? (32'h400 | h[9:0]) : h[9:0];
        e = (h[14:10] != 0) ? h[14:10] : 1;
        p = m * mag;
        t = 0;
        while (t < 31 && (p >> (t + 1)) != 0)
            t++;
        return sgn | ((t + e + 102) << 23) | ((p << (23 - t)) & 32'h7F_FFFF);
    endfunction

    function automatic logic [7:0] block_byte(block_t b, int i);
        logic [255:0] all;
        all = {b.w3, b.w2, b.w1, b.w0};
        return all[i*8 +: 8];
    endfunction

    function automatic logic [31:0] dequant_elem(block_t b, int i);
        logic [7:0] by;
        case (model_fmt)
            FMT_F32:  return (i < 2) ? b.w0[(i%2)*32 +: 32] : b.w1[(i%2)*32 +: 32];
            FMT_F16:  return widen_half(b.w0[i*16 +: 16]);
            FMT_Q4_0:
            begin
                by = block_byte(b, i % 16);
                return scale_int(b.scale, (i < 16 ? int'(by[3:0]) : int'(by[7:4])) - 8);
            end
            default:
            begin
                by = block_byte(b, i);
                return scale_int(b.scale, int'($signed(by)));
            end
        endcase
    endfunction

    function automatic void predict_groups(block_t b);
        int     n;
        group_t g;
        n = (model_fmt == FMT_F32 || model_fmt == FMT_F16) ? 1 : GROUPS;
        for (int k = 0; k < n; k++)
        begin
            g.l0   = dequant_elem(b, k*4);
            g.l1   = dequant_elem(b, k*4 + 1);
            g.l2   = dequant_elem(b, k*4 + 2);
            g.l3   = dequant_elem(b, k*4 + 3);
            g.last = (k == n - 1);
            pending_groups.push_back(g);
        end
    endfunction

    // Output side: random stall, plus a long hold on request.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        group_t g;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_groups.size() == 0)
            begin
                $error("unexpected output beat lane0=%h", lane0);
                err_count++;
            end
            else
            begin
                g = pending_groups.pop_front();
                if (lane0 !== g.l0)
                begin
                    $error("lane0 exp %h got %h", g.l0, lane0);
                    err_count++;
                end
                if (lane1 !== g.l1)
                begin
                    $error("lane1 exp %h got %h", g.l1, lane1);
                    err_count++;
                end
                if (lane2 !== g.l2)
                begin
                    $error("lane2 exp %h got %h", g.l2, lane2);
                    err_count++;
                end
                if (lane3 !== g.l3)
                begin
                    $error("lane3 exp %h got %h", g.l3, lane3);
                    err_count++;
                end
                if (last_of_block !== g.last)
                begin
                    $error("last_of_block exp %b got %b", g.last, last_of_block);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_block(block_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        scale_half <= b.scale;
        data_word0 <= b.w0;
        data_word1 <= b.w1;
        data_word2 <= b.w2;
        data_word3 <= b.w3;
        do
            @(posedge clk);
        while (in_stall);
        predict_groups(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_format(fmt_t f);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= f;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_fmt = f;
    endtask

    function automatic logic [15:0] pick_scale();
        logic [15:0] odd[8] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00,
                                16'h7E01, 16'h0001, 16'h7BFF, 16'h83FF};
        if ($urandom_range(3) == 0)
            return odd[$urandom_range(7)];
        return 16'($urandom);
    endfunction

    function automatic block_t rand_block();
        block_t b;
        b.scale = pick_scale();
        b.w0 = {$urandom, $urandom};
        b.w1 = {$urandom, $urandom};
        b.w2 = {$urandom, $urandom};
        b.w3 = {$urandom, $urandom};
        return b;
    endfunction

    // Reset value of format is Q4_0: send blocks before any write.
    task automatic test_reset_format();
        send_block('{16'h3C00, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                     64'd0, 64'd0});
        send_block('{16'h7C00, 64'h8888_8888_0000_FFFF, 64'h0F0F_F0F0_8787_7878,
                     64'd0, 64'd0});
    endtask

    task automatic test_directed();
        logic [15:0] scales[6] = '{16'h0000, 16'h8000, 16'hFC00, 16'h7E01,
                                   16'h0001, 16'h7BFF};
        set_format(FMT_F32);
        send_block('{16'hFFFF, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0});
        send_block('{16'h0000, '1, '1, 64'd0, '1});
        set_format(FMT_F16);
        send_block('{16'h0, 64'h7C00_FC00_8000_0000, 64'd0, 64'd0, 64'd0});
        send_block('{16'h0, 64'h7E01_7D55_0001_83FF, 64'd0, 64'd0, 64'd0});
        send_block('{16'h0, 64'h7BFF_FBFF_0400_8401, 64'd0, 64'd0, 64'd0});
        set_format(FMT_Q4_0);
        foreach (scales[i])
            send_block('{scales[i], 64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0,
                         '1, '1});
        set_format(FMT_Q8_0);
        foreach (scales[i])
            send_block('{scales[i], 64'h0001_7F80_FF81_807F, 64'h0102_0408_1020_4080,
                         '1, 64'h8000_0000_0000_007F});
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++)
        begin
            if (k % 35 == 0)
                set_format(fmt_t'($urandom_range(3)));
            send_block(rand_block());
        end
    endtask

    // Hold the output for a long stretch while blocks keep coming.
    task automatic test_backpressure();
        set_format(FMT_Q8_0);
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
            send_block(rand_block());
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_format();
        test_directed();
        send_idle_pct = 16;
        recv_idle_pct = 79;
        test_random(140);
        send_idle_pct = 79;
        recv_idle_pct = 16;
        test_random(140);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(110);
        test_backpressure();
        drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* sim.f */
rtl/bqd_pkg.sv
rtl/bqd_lane.sv
rtl/block_quant_dequantizer.sv
tb/block_quant_dequantizer_tb.sv
